FILE: hw/rtl/abst_pkg.sv
// Package for the binary search tree block: opcodes, result status codes,
// field widths, controller states and default sizes.
// Depends on nothing; included first in compile order.
`timescale 1ns / 1ps
`default_nettype none

package abst_pkg;

   // Default number of node table slots.
   localparam int MAX_NODES_DEFAULT = 32;
   // A dump never returns more than this many keys.
   localparam int RESULT_CAP = 32;

   // Field widths on the ports.
   localparam int OPCODE_W = 2;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 3;
   localparam int NODE_W   = 5;
   localparam int PARENT_W = 6;

   // Parent field value for a root, an unlinked node and every non-insert result.
   localparam logic [PARENT_W-1:0] PARENT_NONE = '1;

   // Request opcodes.
   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DUMP   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STS_LINKED  = 3'd0;
   localparam logic [STATUS_W-1:0] STS_DUP     = 3'd1;
   localparam logic [STATUS_W-1:0] STS_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] STS_DUMP    = 3'd3;
   localparam logic [STATUS_W-1:0] STS_EMPTY   = 3'd4;
   localparam logic [STATUS_W-1:0] STS_CLEARED = 3'd5;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_PAR,
      ST_ONE,
      ST_DOWN,
      ST_UP
   } st_type;

endpackage

`default_nettype wire

FILE: hw/rtl/array_bst_insert_inorder.sv
// Binary search tree in a node table: insert, in-order dump and clear. Uses abst_pkg.
// An insert walks one tree level per memory read; a link-in then writes the new node's
// parent link before its result is staged, while a duplicate key stages its result at
// once. A root insert, clear, empty dump or full-table insert stages its result directly;
// a dump sends its keys in order. Requests are taken one at a time, the next taken once
// the final result is registered. Reset clears the counts.
`timescale 1ns / 1ps
`default_nettype none

module array_bst_insert_inorder #(
   parameter int MAX_NODES = abst_pkg::MAX_NODES_DEFAULT
) (
   input  wire                                     clock,
   input  wire                                     reset,

   input  wire                                     req_valid,
   output logic                                    req_stall,
   input  wire  [abst_pkg::OPCODE_W-1:0]           req_opcode,
   input  wire  signed [abst_pkg::KEY_W-1:0]       req_key,

   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output logic [abst_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [abst_pkg::KEY_W-1:0]       rsp_out_key,
   output logic [abst_pkg::NODE_W-1:0]             rsp_node_index,
   output logic signed [abst_pkg::PARENT_W-1:0]    rsp_parent_index,
   output logic                                    rsp_went_right,
   output logic                                    rsp_last
);
   import abst_pkg::*;

   // Slot index width and a count width that can hold MAX_NODES itself.
   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   // The dump result limit as it applies to this table size.
   localparam int CAP_EFF = (MAX_NODES < RESULT_CAP) ? MAX_NODES : RESULT_CAP;

   // Slot 0 always holds the root and is never anyone's child, so a link
   // value of zero means "no child". This saves a valid bit per link. The
   // parent field is only followed for nodes other than the root.
   typedef struct packed {
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic [IDX_W-1:0] parent;
   } link_type;

   // Node table: one memory for the keys, one for the links of each slot.
   // Both are read at the same address every cycle through registered read ports.
   // The controller, the count, the linked count and the result valid are reset;
   // the memories are not cleared.
   logic [KEY_W-1:0] key_mem  [MAX_NODES];
   link_type         link_mem [MAX_NODES];

   logic signed [KEY_W-1:0] key_rd_ff;
   link_type                link_rd_ff;

   logic                    key_we;
   logic [IDX_W-1:0]        key_wa;
   logic [KEY_W-1:0]        key_wd;
   logic                    link_we;
   logic [IDX_W-1:0]        link_wa;
   link_type                link_wd;

   // Controller state.
   st_type                  state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;      // slots in use
   logic [CNT_W-1:0]        linked_ff, linked_in;    // slots reachable from the root
   logic [IDX_W-1:0]        cur_ff, cur_in;          // node whose entry is on the read port
   logic [IDX_W-1:0]        child_ff, child_in;      // node the dump climbs up from
   logic [IDX_W-1:0]        slot_ff, slot_in;        // slot taken by the insert
   logic [CNT_W-1:0]        emitted_ff, emitted_in;  // dump results sent so far
   logic signed [KEY_W-1:0] key_ff, key_in;

   // Staged fields of a single-result request.
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic [NODE_W-1:0]       res_node_ff, res_node_in;
   logic [PARENT_W-1:0]     res_parent_ff, res_parent_in;
   logic                    res_right_ff, res_right_in;

   // Result output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]        rsp_key_ff, rsp_key_in;
   logic [NODE_W-1:0]       rsp_node_ff, rsp_node_in;
   logic [PARENT_W-1:0]     rsp_parent_ff, rsp_parent_in;
   logic                    rsp_right_ff, rsp_right_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    emit_go;
   logic                    emit_dump;
   logic                    out_free;
   logic                    full;
   logic [IDX_W-1:0]        slot_now;
   logic                    key_gt;
   logic                    key_eq;
   logic [CNT_W-1:0]        dump_limit;
   logic                    dump_last;

   // The output register can take a new result when it is empty or its
   // current result transfers at this edge.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = (count_ff == CNT_W'(MAX_NODES));
   assign slot_now  = count_ff[IDX_W-1:0];
   assign key_gt    = key_ff > key_rd_ff;
   assign key_eq    = key_ff == key_rd_ff;
   // Every linked node is visited exactly once, so the dump knows its final
   // result from the linked count, capped at the result limit.
   assign dump_limit = (linked_ff > CNT_W'(CAP_EFF)) ? CNT_W'(CAP_EFF) : linked_ff;
   assign dump_last  = ((emitted_ff + CNT_W'(1)) == dump_limit);

   assign req_stall = (state_ff != ST_IDLE);

   // Next state, memory writes and result selection.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      linked_in     = linked_ff;
      cur_in        = cur_ff;
      child_in      = child_ff;
      slot_in       = slot_ff;
      emitted_in    = emitted_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_node_in   = res_node_ff;
      res_parent_in = res_parent_ff;
      res_right_in  = res_right_ff;

      key_we  = 1'b0;
      key_wa  = slot_ff;
      key_wd  = key_ff;
      link_we = 1'b0;
      link_wa = cur_ff;
      link_wd = '0;

      emit_go       = 1'b0;
      emit_dump     = 1'b0;
      rsp_status_in = STS_DUMP;
      rsp_key_in    = key_rd_ff;
      rsp_node_in   = NODE_W'(cur_ff);
      rsp_parent_in = PARENT_NONE;
      rsp_right_in  = 1'b0;
      rsp_last_in   = dump_last;

      unique case (state_ff)
         ST_IDLE: begin
            // The read port sits on the root while idle, so a walk can
            // start comparing in the cycle after the request transfers.
            cur_in = '0;
            if (req_valid) begin
               key_in = '0;
               unique case (req_opcode)
                  OP_INSERT: begin
                     key_in = req_key;
                     if (full) begin
                        res_status_in = STS_FULL;
                        res_node_in   = '0;
                        res_parent_in = PARENT_NONE;
                        res_right_in  = 1'b0;
                        state_in      = ST_ONE;
                     end else begin
                        // Store the key and empty links in the next free slot.
                        key_we   = 1'b1;
                        key_wa   = slot_now;
                        key_wd   = req_key;
                        link_we  = 1'b1;
                        link_wa  = slot_now;
                        link_wd  = '0;
                        count_in = count_ff + CNT_W'(1);
                        slot_in  = slot_now;
                        if (count_ff == '0) begin
                           linked_in     = linked_ff + CNT_W'(1);
                           res_status_in = STS_LINKED;
                           res_node_in   = '0;
                           res_parent_in = PARENT_NONE;
                           res_right_in  = 1'b0;
                           state_in      = ST_ONE;
                        end else begin
                           state_in = ST_WALK;
                        end
                     end
                  end
                  OP_DUMP: begin
                     if (count_ff == '0) begin
                        res_status_in = STS_EMPTY;
                        res_node_in   = '0;
                        res_parent_in = PARENT_NONE;
                        res_right_in  = 1'b0;
                        state_in      = ST_ONE;
                     end else begin
                        emitted_in = '0;
                        state_in   = ST_DOWN;
                     end
                  end
                  OP_CLEAR: begin
                     count_in      = '0;
                     linked_in     = '0;
                     res_status_in = STS_CLEARED;
                     res_node_in   = '0;
                     res_parent_in = PARENT_NONE;
                     res_right_in  = 1'b0;
                     state_in      = ST_ONE;
                  end
                  default: begin
                     // The unused opcode is dropped without a result.
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_WALK: begin
            // One tree level per cycle: compare with the node on the read
            // port and either link in or move the read port to the child.
            if (key_eq) begin
               res_status_in = STS_DUP;
               res_node_in   = NODE_W'(slot_ff);
               res_parent_in = PARENT_NONE;
               res_right_in  = 1'b0;
               cur_in        = '0;
               state_in      = ST_ONE;
            end else if (key_gt) begin
               if (link_rd_ff.right == '0) begin
                  link_we       = 1'b1;
                  link_wa       = cur_ff;
                  link_wd       = '{left: link_rd_ff.left, right: slot_ff,
                                    parent: link_rd_ff.parent};
                  linked_in     = linked_ff + CNT_W'(1);
                  res_status_in = STS_LINKED;
                  res_node_in   = NODE_W'(slot_ff);
                  res_parent_in = PARENT_W'(cur_ff);
                  res_right_in  = 1'b1;
                  state_in      = ST_PAR;
               end else begin
                  cur_in = link_rd_ff.right;
               end
            end else begin
               if (link_rd_ff.left == '0) begin
                  link_we       = 1'b1;
                  link_wa       = cur_ff;
                  link_wd       = '{left: slot_ff, right: link_rd_ff.right,
                                    parent: link_rd_ff.parent};
                  linked_in     = linked_ff + CNT_W'(1);
                  res_status_in = STS_LINKED;
                  res_node_in   = NODE_W'(slot_ff);
                  res_parent_in = PARENT_W'(cur_ff);
                  res_right_in  = 1'b0;
                  state_in      = ST_PAR;
               end else begin
                  cur_in = link_rd_ff.left;
               end
            end
         end

         ST_PAR: begin
            // Second write of a link-in: the new node records its parent.
            link_we  = 1'b1;
            link_wa  = slot_ff;
            link_wd  = '{left: '0, right: '0, parent: cur_ff};
            cur_in   = '0;
            state_in = ST_ONE;
         end

         ST_ONE: begin
            cur_in        = '0;
            rsp_status_in = res_status_ff;
            rsp_key_in    = key_ff;
            rsp_node_in   = res_node_ff;
            rsp_parent_in = res_parent_ff;
            rsp_right_in  = res_right_ff;
            rsp_last_in   = 1'b1;
            if (out_free) begin
               emit_go  = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_DOWN: begin
            // Descend along left links; a node without a left child is next in order.
            if (link_rd_ff.left != '0) begin
               cur_in = link_rd_ff.left;
            end else if (out_free) begin
               emit_go   = 1'b1;
               emit_dump = 1'b1;
            end
         end

         ST_UP: begin
            // Climbing: arriving from a left child means this node is next
            // in order; arriving from a right child means keep climbing.
            if (link_rd_ff.left == child_ff) begin
               if (out_free) begin
                  emit_go   = 1'b1;
                  emit_dump = 1'b1;
               end
            end else begin
               child_in = cur_ff;
               cur_in   = link_rd_ff.parent;
            end
         end

         default: begin
            state_in = ST_IDLE;
            cur_in   = '0;
         end
      endcase

      // After a dump key is sent: stop on the final one, otherwise go into
      // the right subtree, or climb when there is none.
      if (emit_dump) begin
         emitted_in = emitted_ff + CNT_W'(1);
         if (dump_last) begin
            cur_in   = '0;
            state_in = ST_IDLE;
         end else if (link_rd_ff.right != '0) begin
            cur_in   = link_rd_ff.right;
            state_in = ST_DOWN;
         end else begin
            child_in = cur_ff;
            cur_in   = link_rd_ff.parent;
            state_in = ST_UP;
         end
      end

      rsp_valid_in = emit_go || (rsp_valid_ff && rsp_stall);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         linked_ff    <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         linked_ff    <= linked_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      child_ff      <= child_in;
      slot_ff       <= slot_in;
      emitted_ff    <= emitted_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_node_ff   <= res_node_in;
      res_parent_ff <= res_parent_in;
      res_right_ff  <= res_right_in;
      if (emit_go) begin
         rsp_status_ff <= rsp_status_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_node_ff   <= rsp_node_in;
         rsp_parent_ff <= rsp_parent_in;
         rsp_right_ff  <= rsp_right_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // Key memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_wa] <= key_wd;
      end
      key_rd_ff <= key_mem[cur_in];
   end

   // Link memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[cur_in];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_key      = rsp_key_ff;
   assign rsp_node_index   = rsp_node_ff;
   assign rsp_parent_index = rsp_parent_ff;
   assign rsp_went_right   = rsp_right_ff;
   assign rsp_last         = rsp_last_ff;

   // Every linked node occupies a slot, and the slot count stays within the table.
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (linked_ff <= count_ff) && (count_ff <= CNT_W'(MAX_NODES)))
      else $error("linked or slot count out of range");

   // A dump in progress has not yet sent its final key.
   a_dump_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DOWN || state_ff == ST_UP) |-> (emitted_ff < dump_limit))
      else $error("dump ran past its final key");

   // The final result of a request returns the controller to idle.
   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (emit_go && rsp_last_in) |=> (state_ff == ST_IDLE))
      else $error("controller busy after final result");

   // A clear empties the table on the next cycle.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode == OP_CLEAR) |=>
      (count_ff == '0 && linked_ff == '0))
      else $error("table not empty after clear");

endmodule

`default_nettype wire
